// ----- hdl/arfm_pkg.sv -----
// Package for the rocket aerodynamic force and moment block.
// Holds widths, register indexes, output slot names and shared types.
// No dependencies.
package arfm_pkg;

  localparam int OUT_WIDTH_DEF = 40;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = IDX_W + 2;

  localparam logic [IDX_W-1:0] REG_AREA_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIA_AXIAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORMAL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_PITCH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_PITCH_ROLL = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROLL_SIDE = 3'd5;
  localparam logic [IDX_W-1:0] REG_SIDE_YAW  = 3'd6;
  localparam logic [IDX_W-1:0] REG_YAW       = 3'd7;

  localparam int V_W    = 16;
  localparam int Q_W    = 24;
  localparam int ANG_W  = 16;
  localparam int COEF_W = 16;
  localparam int QS_W   = Q_W + COEF_W;

  localparam int DVD_W      = 32;
  localparam int DVS_W      = V_W + 2;
  localparam int DIV_STAGES = DVD_W;
  localparam int RATE_W     = 32;

  localparam int SUM_W  = 50;
  localparam int MAG_W  = SUM_W;
  localparam int MUL_W  = QS_W + COEF_W;
  localparam int SPLIT  = 32;
  localparam int PART_W = MAG_W + MUL_W;

  localparam int SCALE_STAGES = 4;
  localparam int SH_AXIAL  = 19;
  localparam int SH_FORCE  = 32;
  localparam int SH_MOMENT = 40;

  localparam int NUM_OUT = 6;
  localparam int OUT_FX = 0;
  localparam int OUT_FY = 1;
  localparam int OUT_FZ = 2;
  localparam int OUT_MX = 3;
  localparam int OUT_MY = 4;
  localparam int OUT_MZ = 5;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] arfm_regs_t;

  // Angles and flags that ride alongside the rate dividers.
  typedef struct packed {
    logic [ANG_W-1:0] alpha;
    logic [ANG_W-1:0] beta;
    logic [ANG_W-1:0] de;
    logic [ANG_W-1:0] da;
    logic [ANG_W-1:0] dr;
    logic [QS_W-1:0]  qs;
    logic             zero;
    logic             neg_p;
    logic             neg_q;
    logic             neg_r;
  } arfm_side_t;

  function automatic logic [ANG_W-1:0] abs16(input logic signed [ANG_W-1:0] x);
    abs16 = x[ANG_W-1] ? ANG_W'(-x) : ANG_W'(x);
  endfunction

endpackage

// ----- hdl/arfm_if.sv -----
// Channel interfaces for the input and result words of the aero block.
// Depends on nothing; widths follow the field definitions.
interface arfm_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        airspeed;
  logic [23:0]        dyn_pressure;
  logic signed [15:0] angle_of_attack;
  logic signed [15:0] sideslip;
  logic signed [15:0] roll_rate;
  logic signed [15:0] pitch_rate;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] elevator_angle;
  logic signed [15:0] aileron_angle;
  logic signed [15:0] rudder_angle;

  modport source (output valid, airspeed, dyn_pressure, angle_of_attack, sideslip,
                  roll_rate, pitch_rate, yaw_rate, elevator_angle, aileron_angle,
                  rudder_angle, input ready);
  modport sink (input valid, airspeed, dyn_pressure, angle_of_attack, sideslip,
                roll_rate, pitch_rate, yaw_rate, elevator_angle, aileron_angle,
                rudder_angle, output ready);
endinterface

interface arfm_out_if #(parameter int OUT_WIDTH = 40);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] force_x;
  logic signed [OUT_WIDTH-1:0] force_y;
  logic signed [OUT_WIDTH-1:0] force_z;
  logic signed [OUT_WIDTH-1:0] moment_x;
  logic signed [OUT_WIDTH-1:0] moment_y;
  logic signed [OUT_WIDTH-1:0] moment_z;
  logic                        saturated;

  modport source (output valid, force_x, force_y, force_z, moment_x, moment_y, moment_z,
                  saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, moment_x, moment_y, moment_z,
                saturated, output ready);
endinterface

// ----- hdl/rocket_aero_force_moment.sv -----
// Top level of the rocket aerodynamic force and moment block.
// Depends on arfm_pkg, arfm_if, arfm_cfg, arfm_rate_div and arfm_scale.
//
// Each input word (air data, body rates, control deflections) yields one
// result word of three body forces, three body moments and a saturation
// flag, built from linear stability derivatives held in eight APB
// registers. The block takes one word per clock unless the output stalls,
// and passes each through one input stage, 32 stages of the restoring
// dividers that normalise the body rates by length over four times the
// airspeed (one quotient bit per stage, which sets the depth), a sign
// stage, three stages that form and sum the derivative products, and four
// stages that scale by pressure times area, round and clamp. The pipeline
// moves as a whole: when the result register holds a word that is not
// taken, every stage holds and the input is not ready, so nothing is lost
// or repeated. Zero airspeed or zero pressure gives an all-zero word.
// Registers may be written only while the pipeline is empty.
module rocket_aero_force_moment #(
  parameter int OUT_WIDTH = arfm_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arfm_in_if.sink                     in_ch,
  arfm_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [arfm_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [arfm_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [arfm_pkg::REG_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import arfm_pkg::*;

  // Stage count from input register to result register.
  localparam int LAT = 1 + DIV_STAGES + 4 + SCALE_STAGES;
  localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Registers and the coefficient fields carved out of them.
  // ---------------------------------------------------------------------
  arfm_regs_t regs;

  arfm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs_o  (regs)
  );

  logic [COEF_W-1:0]        ref_s, ref_l, ref_d;
  logic signed [COEF_W-1:0] ca0, cna, cnde, cma, cmq, cmde, clp, clda;
  logic signed [COEF_W-1:0] cyb, cydr, cnb, cnr, cndr;

  assign ref_s = regs[REG_AREA_LEN][15:0];
  assign ref_l = regs[REG_AREA_LEN][31:16];
  assign ref_d = regs[REG_DIA_AXIAL][15:0];
  assign ca0   = $signed(regs[REG_DIA_AXIAL][31:16]);
  assign cna   = $signed(regs[REG_NORMAL][15:0]);
  assign cnde  = $signed(regs[REG_NORMAL][31:16]);
  assign cma   = $signed(regs[REG_PITCH][15:0]);
  assign cmq   = $signed(regs[REG_PITCH][31:16]);
  assign cmde  = $signed(regs[REG_PITCH_ROLL][15:0]);
  assign clp   = $signed(regs[REG_PITCH_ROLL][31:16]);
  assign clda  = $signed(regs[REG_ROLL_SIDE][15:0]);
  assign cyb   = $signed(regs[REG_ROLL_SIDE][31:16]);
  assign cydr  = $signed(regs[REG_SIDE_YAW][15:0]);
  assign cnb   = $signed(regs[REG_SIDE_YAW][31:16]);
  assign cnr   = $signed(regs[REG_YAW][15:0]);
  assign cndr  = $signed(regs[REG_YAW][31:16]);

  // ---------------------------------------------------------------------
  // Flow control: one enable for the whole pipeline, valid bits alongside.
  // ---------------------------------------------------------------------
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: rate magnitudes times reference diameter or length, q times S.
  // ---------------------------------------------------------------------
  logic [DVD_W-1:0] s1_magp_r, s1_magq_r, s1_magr_r;
  logic [V_W-1:0]   s1_v_r;
  arfm_side_t       s1_side_r;
  arfm_side_t       s1_side_nxt;

  always_comb begin
    s1_side_nxt.alpha = in_ch.angle_of_attack;
    s1_side_nxt.beta  = in_ch.sideslip;
    s1_side_nxt.de    = in_ch.elevator_angle;
    s1_side_nxt.da    = in_ch.aileron_angle;
    s1_side_nxt.dr    = in_ch.rudder_angle;
    s1_side_nxt.qs    = in_ch.dyn_pressure * ref_s;
    s1_side_nxt.zero  = (in_ch.airspeed == '0) || (in_ch.dyn_pressure == '0);
    s1_side_nxt.neg_p = in_ch.roll_rate[ANG_W-1];
    s1_side_nxt.neg_q = in_ch.pitch_rate[ANG_W-1];
    s1_side_nxt.neg_r = in_ch.yaw_rate[ANG_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_magp_r <= abs16(in_ch.roll_rate) * ref_d;
      s1_magq_r <= abs16(in_ch.pitch_rate) * ref_l;
      s1_magr_r <= abs16(in_ch.yaw_rate) * ref_l;
      s1_v_r    <= in_ch.airspeed;
      s1_side_r <= s1_side_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Rate normalisation: (mag + 2V) / 4V rounds half away from zero.
  // ---------------------------------------------------------------------
  logic [DVD_W-1:0] div_bias;
  logic [DVS_W-1:0] div_den;
  logic [DVD_W-1:0] quo_p, quo_q, quo_r;

  assign div_bias = DVD_W'({s1_v_r, 1'b0});
  assign div_den  = {s1_v_r, 2'b00};

  arfm_rate_div u_div_p (
    .clk(clk), .en(en), .dividend_i(s1_magp_r + div_bias), .divisor_i(div_den),
    .quotient_o(quo_p)
  );
  arfm_rate_div u_div_q (
    .clk(clk), .en(en), .dividend_i(s1_magq_r + div_bias), .divisor_i(div_den),
    .quotient_o(quo_q)
  );
  arfm_rate_div u_div_r (
    .clk(clk), .en(en), .dividend_i(s1_magr_r + div_bias), .divisor_i(div_den),
    .quotient_o(quo_r)
  );

  // Angles and flags wait in a delay line matched to the divider depth.
  arfm_side_t side_line_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      side_line_r[0] <= s1_side_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_line_r[i] <= side_line_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sign stage: the quotients take back the sign of their rates.
  // ---------------------------------------------------------------------
  arfm_side_t               sg_side_r;
  arfm_side_t               div_tail;
  logic signed [RATE_W-1:0] phat_r, qhat_r, rhat_r;

  assign div_tail = side_line_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sg_side_r <= div_tail;
      phat_r    <= div_tail.neg_p ? -$signed(quo_p) : $signed(quo_p);
      qhat_r    <= div_tail.neg_q ? -$signed(quo_q) : $signed(quo_q);
      rhat_r    <= div_tail.neg_r ? -$signed(quo_r) : $signed(quo_r);
    end
  end

  // ---------------------------------------------------------------------
  // Product stage: every derivative but ca0 times its angle or normalised rate,
  // and the moment multipliers q*S*D and q*S*L.
  // ---------------------------------------------------------------------
  localparam int PA_W = 2 * COEF_W;
  localparam int PR_W = COEF_W + RATE_W;

  logic signed [PA_W-1:0] cna_a_r, cnde_de_r, cyb_b_r, cydr_dr_r, clda_da_r;
  logic signed [PA_W-1:0] cma_a_r, cmde_de_r, cnb_b_r, cndr_dr_r;
  logic signed [PR_W-1:0] clp_p_r, cmq_q_r, cnr_r_r;
  logic [QS_W-1:0]        m1_qs_r;
  logic [MUL_W-1:0]       m1_qsd_r, m1_qsl_r;
  logic                   m1_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cna_a_r   <= cna  * $signed(sg_side_r.alpha);
      cnde_de_r <= cnde * $signed(sg_side_r.de);
      cyb_b_r   <= cyb  * $signed(sg_side_r.beta);
      cydr_dr_r <= cydr * $signed(sg_side_r.dr);
      clda_da_r <= clda * $signed(sg_side_r.da);
      cma_a_r   <= cma  * $signed(sg_side_r.alpha);
      cmde_de_r <= cmde * $signed(sg_side_r.de);
      cnb_b_r   <= cnb  * $signed(sg_side_r.beta);
      cndr_dr_r <= cndr * $signed(sg_side_r.dr);
      clp_p_r   <= clp  * phat_r;
      cmq_q_r   <= cmq  * qhat_r;
      cnr_r_r   <= cnr  * rhat_r;
      m1_qs_r   <= sg_side_r.qs;
      m1_qsd_r  <= sg_side_r.qs * ref_d;
      m1_qsl_r  <= sg_side_r.qs * ref_l;
      m1_zero_r <= sg_side_r.zero;
    end
  end

  // ---------------------------------------------------------------------
  // Sum stage: coefficient sums in Q.24, forced to zero for a still or
  // airless word so that the scaler returns plain zeros.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] c_nxt [NUM_OUT];
  logic signed [SUM_W-1:0] c_r   [NUM_OUT];
  logic [MUL_W-1:0]        m2_mul_r [NUM_OUT];

  always_comb begin
    c_nxt[OUT_FX] = -SUM_W'(ca0);
    c_nxt[OUT_FY] = SUM_W'(cyb_b_r) + SUM_W'(cydr_dr_r);
    c_nxt[OUT_FZ] = -(SUM_W'(cna_a_r) + SUM_W'(cnde_de_r));
    c_nxt[OUT_MX] = SUM_W'(clp_p_r) + SUM_W'(clda_da_r);
    c_nxt[OUT_MY] = SUM_W'(cma_a_r) + SUM_W'(cmq_q_r) + SUM_W'(cmde_de_r);
    c_nxt[OUT_MZ] = SUM_W'(cnb_b_r) + SUM_W'(cnr_r_r) + SUM_W'(cndr_dr_r);
    if (m1_zero_r) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        c_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        c_r[k] <= c_nxt[k];
      end
      m2_mul_r[OUT_FX] <= MUL_W'(m1_qs_r);
      m2_mul_r[OUT_FY] <= MUL_W'(m1_qs_r);
      m2_mul_r[OUT_FZ] <= MUL_W'(m1_qs_r);
      m2_mul_r[OUT_MX] <= m1_qsd_r;
      m2_mul_r[OUT_MY] <= m1_qsl_r;
      m2_mul_r[OUT_MZ] <= m1_qsl_r;
    end
  end

  // ---------------------------------------------------------------------
  // Magnitude stage: the scalers work on sign and magnitude.
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] mag_r [NUM_OUT];
  logic             neg_r [NUM_OUT];
  logic [MUL_W-1:0] m3_mul_r [NUM_OUT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        mag_r[k]    <= c_r[k][SUM_W-1] ? MAG_W'(-c_r[k]) : MAG_W'(c_r[k]);
        neg_r[k]    <= c_r[k][SUM_W-1];
        m3_mul_r[k] <= m2_mul_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Scaling to whole units: the axial force keeps its Q4.11 coefficient
  // over Q8.8 area, the other forces carry Q.24 sums, the moments one more
  // Q8.8 length.
  // ---------------------------------------------------------------------
  logic signed [OUT_WIDTH-1:0] val [NUM_OUT];
  logic [NUM_OUT-1:0]          sat;

  for (genvar k = 0; k < NUM_OUT; k++) begin : g_scale
    localparam int SH = (k == OUT_FX) ? SH_AXIAL : ((k < OUT_MX) ? SH_FORCE : SH_MOMENT);
    arfm_scale #(
      .OUT_WIDTH (OUT_WIDTH),
      .SHIFT     (SH)
    ) u_scale (
      .clk     (clk),
      .en      (en),
      .mag_i   (mag_r[k]),
      .neg_i   (neg_r[k]),
      .mul_i   (m3_mul_r[k]),
      .value_o (val[k]),
      .sat_o   (sat[k])
    );
  end

  assign out_ch.valid     = vld_r[LAT-1];
  assign out_ch.force_x   = val[OUT_FX];
  assign out_ch.force_y   = val[OUT_FY];
  assign out_ch.force_z   = val[OUT_FZ];
  assign out_ch.moment_x  = val[OUT_MX];
  assign out_ch.moment_y  = val[OUT_MY];
  assign out_ch.moment_z  = val[OUT_MZ];
  assign out_ch.saturated = |sat;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  logic at_lim;

  always_comb begin
    at_lim = 1'b0;
    for (int k = 0; k < NUM_OUT; k++) begin
      if (val[k] == OUT_MAX || val[k] == OUT_MIN) begin
        at_lim = 1'b1;
      end
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |-> at_lim)
    else $error("saturated word has no output at a range limit");

endmodule

// ----- hdl/arfm_cfg.sv -----
// APB-style register file holding the reference sizes and derivatives.
// Depends on arfm_pkg.
module arfm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arfm_pkg::ADDR_W-1:0] paddr,
  input  logic [arfm_pkg::REG_W-1:0]  pwdata,
  output logic [arfm_pkg::REG_W-1:0]  prdata,
  output logic                        pready,
  output arfm_pkg::arfm_regs_t        regs_o
);
  import arfm_pkg::*;

  arfm_regs_t       regs_r;
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = regs_r[idx];
  assign regs_o = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (wr) begin
      regs_r[idx] <= pwdata;
    end
  end

endmodule

// ----- hdl/arfm_rate_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on arfm_pkg.
module arfm_rate_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [arfm_pkg::DVD_W-1:0] dividend_i,
  input  logic [arfm_pkg::DVS_W-1:0] divisor_i,
  output logic [arfm_pkg::DVD_W-1:0] quotient_o
);
  import arfm_pkg::*;

  // The dividend register shifts left; quotient bits enter at the bottom.
  logic [DVS_W-1:0] rem_r [DIV_STAGES];
  logic [DVD_W-1:0] dvd_r [DIV_STAGES];
  logic [DVS_W-1:0] dvs_r [DIV_STAGES];
  logic [DVS_W-1:0] rem_nxt [DIV_STAGES];
  logic [DVD_W-1:0] dvd_nxt [DIV_STAGES];
  logic [DVS_W-1:0] dvs_nxt [DIV_STAGES];

  always_comb begin
    logic [DVS_W-1:0] src_rem;
    logic [DVD_W-1:0] src_dvd;
    logic [DVS_W-1:0] src_dvs;
    logic [DVS_W:0]   trial;
    logic             ge;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        src_rem = '0;
        src_dvd = dividend_i;
        src_dvs = divisor_i;
      end else begin
        src_rem = rem_r[i-1];
        src_dvd = dvd_r[i-1];
        src_dvs = dvs_r[i-1];
      end
      trial      = {src_rem, src_dvd[DVD_W-1]};
      ge         = trial >= {1'b0, src_dvs};
      rem_nxt[i] = ge ? DVS_W'(trial - {1'b0, src_dvs}) : trial[DVS_W-1:0];
      dvd_nxt[i] = {src_dvd[DVD_W-2:0], ge};
      dvs_nxt[i] = src_dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem_r[i] <= rem_nxt[i];
        dvd_r[i] <= dvd_nxt[i];
        dvs_r[i] <= dvs_nxt[i];
      end
    end
  end

  assign quotient_o = dvd_r[DIV_STAGES-1];

endmodule

// ----- hdl/arfm_scale.sv -----
// Scales a coefficient magnitude by a pressure-area product, rounds and clamps.
// Four register stages; depends on arfm_pkg.
module arfm_scale #(
  parameter int OUT_WIDTH = arfm_pkg::OUT_WIDTH_DEF,
  parameter int SHIFT     = arfm_pkg::SH_FORCE
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [arfm_pkg::MAG_W-1:0]  mag_i,
  input  logic                        neg_i,
  input  logic [arfm_pkg::MUL_W-1:0]  mul_i,
  output logic signed [OUT_WIDTH-1:0] value_o,
  output logic                        sat_o
);
  import arfm_pkg::*;

  localparam int AH_W  = MAG_W - SPLIT;
  localparam int MH_W  = MUL_W - SPLIT;
  localparam int RND_W = PART_W + 1;

  logic [2*SPLIT-1:0]     ll_r;
  logic [SPLIT+MH_W-1:0]  lh_r;
  logic [AH_W+SPLIT-1:0]  hl_r;
  logic [AH_W+MH_W-1:0]   hh_r;
  logic                   neg1_r;
  logic [PART_W-1:0]      prod_r;
  logic [PART_W-1:0]      prod_nxt;
  logic                   neg2_r;
  logic [OUT_WIDTH-1:0]   mag3_r;
  logic [OUT_WIDTH-1:0]   mag3_nxt;
  logic                   neg3_r;
  logic                   sat3_r;
  logic                   sat3_nxt;
  logic signed [OUT_WIDTH-1:0] value_r;
  logic                   sat4_r;
  logic [RND_W-1:0]       rnd;
  logic [RND_W-1:0]       shf;
  logic [RND_W-1:0]       top;
  logic [RND_W-1:0]       lim;

  assign prod_nxt = PART_W'(ll_r) + (PART_W'(lh_r) << SPLIT) + (PART_W'(hl_r) << SPLIT)
                  + (PART_W'(hh_r) << (2 * SPLIT));

  // Round half away from zero on the magnitude, then clamp; the negative
  // limit is one larger than the positive one.
  always_comb begin
    rnd      = RND_W'(prod_r) + (RND_W'(1) << (SHIFT - 1));
    shf      = rnd >> SHIFT;
    top      = RND_W'(1) << (OUT_WIDTH - 1);
    lim      = neg2_r ? top : top - RND_W'(1);
    sat3_nxt = shf > lim;
    mag3_nxt = sat3_nxt ? lim[OUT_WIDTH-1:0] : shf[OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= mag_i[SPLIT-1:0] * mul_i[SPLIT-1:0];
      lh_r    <= mag_i[SPLIT-1:0] * mul_i[MUL_W-1:SPLIT];
      hl_r    <= mag_i[MAG_W-1:SPLIT] * mul_i[SPLIT-1:0];
      hh_r    <= mag_i[MAG_W-1:SPLIT] * mul_i[MUL_W-1:SPLIT];
      neg1_r  <= neg_i;
      prod_r  <= prod_nxt;
      neg2_r  <= neg1_r;
      mag3_r  <= mag3_nxt;
      neg3_r  <= neg2_r;
      sat3_r  <= sat3_nxt;
      value_r <= $signed(neg3_r ? -mag3_r : mag3_r);
      sat4_r  <= sat3_r;
    end
  end

  assign value_o = value_r;
  assign sat_o   = sat4_r;

endmodule

// ----- tb/tb_rocket_aero_force_moment.sv -----
// Self-checking testbench for the rocket aerodynamic force and moment block.
// Depends on arfm_pkg, arfm_if and the block itself; predicts every result
// word from the register settings and compares it field by field.
`timescale 1ns / 1ps

module tb_rocket_aero_force_moment;
  import arfm_pkg::*;

  localparam int OW         = OUT_WIDTH_DEF;
  localparam int LATENCY    = 41;
  localparam int SETTLE     = LATENCY + 20;
  localparam int STALL_CAP  = 3000;
  localparam int RANDOM_LEN = 300;

  // One input word of air data, rates and deflections.
  typedef struct {
    logic [15:0]        airspeed;
    logic [23:0]        dyn_pressure;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] p;
    logic signed [15:0] q;
    logic signed [15:0] r;
    logic signed [15:0] de;
    logic signed [15:0] da;
    logic signed [15:0] dr;
  } flight_state_t;

  // One result word: forces, moments and the clamp flag.
  typedef struct {
    logic [OW-1:0] fx, fy, fz, mx, my, mz;
    logic          sat;
  } aero_load_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [REG_W-1:0]  cfg_pwdata = '0;
  logic [REG_W-1:0]  cfg_prdata;
  logic              cfg_pready;

  arfm_in_if in_ch ();
  arfm_out_if #(.OUT_WIDTH(OW)) out_ch ();

  rocket_aero_force_moment #(.OUT_WIDTH(OW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the derivative registers, kept in step with every write.
  logic [REG_W-1:0] coef_shadow [NUM_REGS];
  aero_load_t expected_loads [$];
  int  errors = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.airspeed = '0;
    in_ch.dyn_pressure = '0;
    in_ch.angle_of_attack = '0;
    in_ch.sideslip = '0;
    in_ch.roll_rate = '0;
    in_ch.pitch_rate = '0;
    in_ch.yaw_rate = '0;
    in_ch.elevator_angle = '0;
    in_ch.aileron_angle = '0;
    in_ch.rudder_angle = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) coef_shadow[i] = '0;
  end

  function automatic longint lo_signed(int idx);
    longint v;
    v = $signed(coef_shadow[idx][15:0]);
    return v;
  endfunction

  function automatic longint hi_signed(int idx);
    longint v;
    v = $signed(coef_shadow[idx][31:16]);
    return v;
  endfunction

  // Body rate times reference length over four times the raw airspeed,
  // rounded to nearest with ties away from zero.
  function automatic longint normalise_rate(longint rate, longint unsigned len,
                                            longint unsigned v);
    longint unsigned mag;
    longint unsigned quo;
    mag = (rate < 0 ? longint'(-rate) : rate) * len;
    quo = (mag + 2 * v) / (4 * v);
    return rate < 0 ? -longint'(quo) : longint'(quo);
  endfunction

  // Coefficient times a scale, shifted down to whole units with rounding,
  // then clamped to the output width.
  function automatic logic [OW-1:0] scale_to_units(longint c, longint unsigned m, int n,
                                                   inout bit sat);
    logic [127:0] prod;
    logic [127:0] qv;
    logic [127:0] limit;
    bit           neg;
    neg   = c < 0;
    prod  = 128'(neg ? longint'(-c) : c) * 128'(m);
    qv    = (prod + (128'd1 << (n - 1))) >> n;
    limit = neg ? (128'd1 << (OW - 1)) : (128'd1 << (OW - 1)) - 1;
    if (qv > limit) begin
      qv  = limit;
      sat = 1'b1;
    end
    return neg ? OW'(-qv) : OW'(qv);
  endfunction

  function automatic aero_load_t predict_loads(flight_state_t s);
    aero_load_t      res;
    bit              sat;
    longint unsigned area, len, dia, qs;
    longint          phat, qhat, rhat, cn, cy, cl, cm, cyaw;
    res  = '{default: '0};
    sat  = 1'b0;
    if (s.airspeed == 0 || s.dyn_pressure == 0) return res;
    area = coef_shadow[REG_AREA_LEN][15:0];
    len  = coef_shadow[REG_AREA_LEN][31:16];
    dia  = coef_shadow[REG_DIA_AXIAL][15:0];
    qs   = longint'(s.dyn_pressure) * area;
    phat = normalise_rate(s.p, dia, s.airspeed);
    qhat = normalise_rate(s.q, len, s.airspeed);
    rhat = normalise_rate(s.r, len, s.airspeed);
    cn   = lo_signed(REG_NORMAL) * s.alpha + hi_signed(REG_NORMAL) * s.de;
    cy   = hi_signed(REG_ROLL_SIDE) * s.beta + lo_signed(REG_SIDE_YAW) * s.dr;
    cl   = hi_signed(REG_PITCH_ROLL) * phat + lo_signed(REG_ROLL_SIDE) * s.da;
    cm   = lo_signed(REG_PITCH) * s.alpha + hi_signed(REG_PITCH) * qhat
         + lo_signed(REG_PITCH_ROLL) * s.de;
    cyaw = hi_signed(REG_SIDE_YAW) * s.beta + lo_signed(REG_YAW) * rhat
         + hi_signed(REG_YAW) * s.dr;
    res.fx = scale_to_units(-hi_signed(REG_DIA_AXIAL), qs, SH_AXIAL, sat);
    res.fy = scale_to_units(cy, qs, SH_FORCE, sat);
    res.fz = scale_to_units(-cn, qs, SH_FORCE, sat);
    res.mx = scale_to_units(cl, qs * dia, SH_MOMENT, sat);
    res.my = scale_to_units(cm, qs * len, SH_MOMENT, sat);
    res.mz = scale_to_units(cyaw, qs * len, SH_MOMENT, sat);
    res.sat = sat;
    return res;
  endfunction

  // The result side: random stall bursts on ready, none once quiet is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (quiet || stall_left == 0) begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 19);
    end else begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // Each accepted result word is compared with the oldest prediction.
  always @(posedge clk) begin
    aero_load_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_loads.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        exp_w = expected_loads.pop_front();
        if (out_ch.force_x !== exp_w.fx) begin
          $error("force_x expected %0d got %0d", $signed(exp_w.fx), out_ch.force_x);
          errors++;
        end
        if (out_ch.force_y !== exp_w.fy) begin
          $error("force_y expected %0d got %0d", $signed(exp_w.fy), out_ch.force_y);
          errors++;
        end
        if (out_ch.force_z !== exp_w.fz) begin
          $error("force_z expected %0d got %0d", $signed(exp_w.fz), out_ch.force_z);
          errors++;
        end
        if (out_ch.moment_x !== exp_w.mx) begin
          $error("moment_x expected %0d got %0d", $signed(exp_w.mx), out_ch.moment_x);
          errors++;
        end
        if (out_ch.moment_y !== exp_w.my) begin
          $error("moment_y expected %0d got %0d", $signed(exp_w.my), out_ch.moment_y);
          errors++;
        end
        if (out_ch.moment_z !== exp_w.mz) begin
          $error("moment_z expected %0d got %0d", $signed(exp_w.mz), out_ch.moment_z);
          errors++;
        end
        if (out_ch.saturated !== exp_w.sat) begin
          $error("saturated expected %0b got %0b", exp_w.sat, out_ch.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // APB write: setup cycle, then access cycle, then idle before
  // the next transfer; pready is always high.
  task automatic write_reg(int idx, logic [REG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    coef_shadow[idx] = value;
    @(posedge clk);
  endtask

  task automatic write_all_regs(logic [REG_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, vals[i]);
  endtask

  // Registers may only change once the pipeline has emptied.
  task automatic wait_drained();
    while (expected_loads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sends one word and records its prediction on acceptance; valid is left
  // high unless a random sender gap follows.
  task automatic send_state(flight_state_t s);
    in_ch.valid           <= 1'b1;
    in_ch.airspeed        <= s.airspeed;
    in_ch.dyn_pressure    <= s.dyn_pressure;
    in_ch.angle_of_attack <= s.alpha;
    in_ch.sideslip        <= s.beta;
    in_ch.roll_rate       <= s.p;
    in_ch.pitch_rate      <= s.q;
    in_ch.yaw_rate        <= s.r;
    in_ch.elevator_angle  <= s.de;
    in_ch.aileron_angle   <= s.da;
    in_ch.rudder_angle    <= s.dr;
    do @(posedge clk); while (!in_ch.ready);
    expected_loads.push_back(predict_loads(s));
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic flight_state_t random_state();
    flight_state_t s;
    s.airspeed     = 16'($urandom_range(0, 65535));
    s.dyn_pressure = 24'($urandom_range(0, 24'hFFFFFF));
    // Slow air gives large normalised rates; zero checks the quiet case.
    case ($urandom_range(0, 15))
      0: s.airspeed = 16'd0;
      1: s.dyn_pressure = 24'd0;
      2, 3: s.airspeed = 16'($urandom_range(1, 15));
      4: s.dyn_pressure = 24'($urandom_range(1, 255));
      default: ;
    endcase
    s.alpha = 16'($urandom); s.beta = 16'($urandom);
    s.p = 16'($urandom); s.q = 16'($urandom); s.r = 16'($urandom);
    s.de = 16'($urandom); s.da = 16'($urandom); s.dr = 16'($urandom);
    return s;
  endfunction

  function automatic flight_state_t uniform_state(logic [15:0] v, logic [23:0] qd,
                                                  logic [15:0] f);
    flight_state_t s;
    s = '{v, qd, f, f, f, f, f, f, f, f};
    return s;
  endfunction

  task automatic set_uniform_regs(logic [REG_W-1:0] value);
    logic [REG_W-1:0] vals [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) vals[i] = value;
    write_all_regs(vals);
  endtask

  task automatic set_random_regs();
    logic [REG_W-1:0] vals [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) vals[i] = $urandom;
    write_all_regs(vals);
  endtask

  // Zero airspeed or pressure must give an all-zero word, whatever else is set.
  task automatic test_zero_air();
    set_uniform_regs(32'h7FFF_7FFF);
    send_state(uniform_state(16'd0, 24'hFFFFFF, 16'h7FFF));
    send_state(uniform_state(16'hFFFF, 24'd0, 16'h8000));
    send_state(uniform_state(16'd0, 24'd0, 16'hFFFF));
    stop_sending();
    wait_drained();
  endtask

  // Field extremes under modest, minus-one and maximum-magnitude derivatives;
  // the largest setting forces some outputs into their clamps.
  task automatic test_extremes();
    logic [REG_W-1:0] sets [3] = '{32'h0100_0100, 32'hFFFF_FFFF, 32'h8000_8000};
    foreach (sets[k]) begin
      set_uniform_regs(sets[k]);
      send_state(uniform_state(16'd1, 24'd1, 16'h0001));
      send_state(uniform_state(16'd1, 24'hFFFFFF, 16'h7FFF));
      send_state(uniform_state(16'd1, 24'hFFFFFF, 16'h8000));
      send_state(uniform_state(16'hFFFF, 24'hFFFFFF, 16'hFFFF));
      send_state(uniform_state(16'hFFFF, 24'd1, 16'h8000));
      send_state(uniform_state(16'h0010, 24'd101325, 16'h0000));
      stop_sending();
      wait_drained();
    end
  endtask

  // Several register settings, each followed by a batch of random words.
  task automatic test_random_flight();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_uniform_regs(32'h0000_0000);
        1: set_uniform_regs(32'h7FFF_7FFF);
        default: set_random_regs();
      endcase
      if (ph == 4) quiet = 1'b1;
      repeat (RANDOM_LEN) send_state(random_state());
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_air();
    test_extremes();
    test_random_flight();
    if (errors == 0 && expected_loads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_loads.size() != 0) $error("%0d results never arrived", expected_loads.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/arfm_pkg.sv
hdl/arfm_if.sv
hdl/arfm_cfg.sv
hdl/arfm_rate_div.sv
hdl/arfm_scale.sv
hdl/rocket_aero_force_moment.sv
tb/tb_rocket_aero_force_moment.sv
